// File: sv/cdcc_pkg.sv
// cdcc_pkg: widths, register codes and shared structs for the colour
// distance cell classifier. no dependencies; every other file uses it.
`default_nettype none

package cdcc_pkg;

  localparam int LANES            = 8;
  localparam int CELL_PIXELS_DEF  = 8;
  localparam int CHAN_W           = 8;
  localparam int PIX_W            = 3 * CHAN_W;
  localparam int SQ_W             = 2 * CHAN_W;
  localparam int SUM_W            = SQ_W + 2;
  localparam int DIST_W           = 9;
  localparam int ROOT_BITS        = SUM_W / 2;
  localparam int REM_W            = DIST_W + 1;
  localparam int CNT_W            = 4;
  localparam int THR_W            = 9;
  localparam int PIPE_STAGES      = 2 + ROOT_BITS;
  localparam int APB_DATA_W       = 32;
  localparam int REG_IDX_W        = 3;
  localparam int APB_ADDR_W       = REG_IDX_W + 2;

  localparam logic [THR_W-1:0] FAR_THR_RESET = THR_W'(442);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_REF_RED   = 3'd0,
    REG_REF_GREEN = 3'd1,
    REG_REF_BLUE  = 3'd2,
    REG_CLOSE_THR = 3'd3,
    REG_FAR_THR   = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [CHAN_W-1:0] ref_red;
    logic [CHAN_W-1:0] ref_green;
    logic [CHAN_W-1:0] ref_blue;
    logic [THR_W-1:0]  close_thr;
    logic [THR_W-1:0]  far_thr;
  } cfg_t;

  typedef struct packed {
    logic                             is_vegetation;
    logic [CNT_W-1:0]                 close_count;
    logic [LANES-1:0][DIST_W-1:0]     lane_dist;
  } res_t;

endpackage

`default_nettype wire

// File: sv/cdcc_if.sv
// cdcc_pix_if and cdcc_res_if: valid/ready channels for pixel cells and
// classification results. depends on cdcc_pkg.
`default_nettype none

interface cdcc_pix_if;
  logic                        valid;
  logic                        ready;
  logic [cdcc_pkg::PIX_W-1:0]  pixel_a;
  logic [cdcc_pkg::PIX_W-1:0]  pixel_b;
  logic [cdcc_pkg::PIX_W-1:0]  pixel_c;
  logic [cdcc_pkg::PIX_W-1:0]  pixel_d;
  logic [cdcc_pkg::PIX_W-1:0]  pixel_e;
  logic [cdcc_pkg::PIX_W-1:0]  pixel_f;
  logic [cdcc_pkg::PIX_W-1:0]  pixel_g;
  logic [cdcc_pkg::PIX_W-1:0]  pixel_h;

  modport source (
    output valid, pixel_a, pixel_b, pixel_c, pixel_d,
           pixel_e, pixel_f, pixel_g, pixel_h,
    input  ready
  );
  modport sink (
    input  valid, pixel_a, pixel_b, pixel_c, pixel_d,
           pixel_e, pixel_f, pixel_g, pixel_h,
    output ready
  );
endinterface

interface cdcc_res_if;
  logic                         valid;
  logic                         ready;
  logic                         is_vegetation;
  logic [cdcc_pkg::CNT_W-1:0]   close_count;
  logic [cdcc_pkg::DIST_W-1:0]  dist_a;
  logic [cdcc_pkg::DIST_W-1:0]  dist_b;
  logic [cdcc_pkg::DIST_W-1:0]  dist_c;
  logic [cdcc_pkg::DIST_W-1:0]  dist_d;
  logic [cdcc_pkg::DIST_W-1:0]  dist_e;
  logic [cdcc_pkg::DIST_W-1:0]  dist_f;
  logic [cdcc_pkg::DIST_W-1:0]  dist_g;
  logic [cdcc_pkg::DIST_W-1:0]  dist_h;

  modport source (
    output valid, is_vegetation, close_count, dist_a, dist_b, dist_c,
           dist_d, dist_e, dist_f, dist_g, dist_h,
    input  ready
  );
  modport sink (
    input  valid, is_vegetation, close_count, dist_a, dist_b, dist_c,
           dist_d, dist_e, dist_f, dist_g, dist_h,
    output ready
  );
endinterface

`default_nettype wire

// File: sv/cdcc_regs.sv
// cdcc_regs: apb register file for reference colour and thresholds.
// depends on cdcc_pkg.
`default_nettype none

module cdcc_regs (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [cdcc_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [cdcc_pkg::APB_DATA_W-1:0]     pwdata,
  output logic      [cdcc_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                     pready,
  output cdcc_pkg::cfg_t                           cfg_o
);

  cdcc_pkg::cfg_t                      cfg_q, cfg_d;
  logic [cdcc_pkg::REG_IDX_W-1:0]      idx;
  logic                                wr_en;

  assign idx    = paddr[cdcc_pkg::APB_ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        cdcc_pkg::REG_REF_RED:   cfg_d.ref_red   = pwdata[cdcc_pkg::CHAN_W-1:0];
        cdcc_pkg::REG_REF_GREEN: cfg_d.ref_green = pwdata[cdcc_pkg::CHAN_W-1:0];
        cdcc_pkg::REG_REF_BLUE:  cfg_d.ref_blue  = pwdata[cdcc_pkg::CHAN_W-1:0];
        cdcc_pkg::REG_CLOSE_THR: cfg_d.close_thr = pwdata[cdcc_pkg::THR_W-1:0];
        cdcc_pkg::REG_FAR_THR:   cfg_d.far_thr   = pwdata[cdcc_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{ref_red: '0, ref_green: '0, ref_blue: '0, close_thr: '0,
                 far_thr: cdcc_pkg::FAR_THR_RESET};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      cdcc_pkg::REG_REF_RED:   prdata = cdcc_pkg::APB_DATA_W'(cfg_q.ref_red);
      cdcc_pkg::REG_REF_GREEN: prdata = cdcc_pkg::APB_DATA_W'(cfg_q.ref_green);
      cdcc_pkg::REG_REF_BLUE:  prdata = cdcc_pkg::APB_DATA_W'(cfg_q.ref_blue);
      cdcc_pkg::REG_CLOSE_THR: prdata = cdcc_pkg::APB_DATA_W'(cfg_q.close_thr);
      cdcc_pkg::REG_FAR_THR:   prdata = cdcc_pkg::APB_DATA_W'(cfg_q.far_thr);
      default:                 prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: sv/cdcc_lane.sv
// cdcc_lane: one pixel's colour distance: squared channel differences,
// their sum, then a one-bit-per-stage square root. depends on cdcc_pkg.
`default_nettype none

module cdcc_lane (
  input  wire logic                              clk_i,
  input  wire logic                              en_i,
  input  wire cdcc_pkg::cfg_t                    cfg_i,
  input  wire logic [cdcc_pkg::PIX_W-1:0]        pixel_i,
  output logic      [cdcc_pkg::DIST_W-1:0]       dist_o
);

  localparam int CW = cdcc_pkg::CHAN_W;
  localparam int RB = cdcc_pkg::ROOT_BITS;

  logic [CW-1:0]                 chan [3];
  logic [CW-1:0]                 refc [3];
  logic [CW-1:0]                 diff [3];
  logic [cdcc_pkg::SQ_W-1:0]     sq_q [3];
  logic [cdcc_pkg::SUM_W-1:0]    sum_q;

  // square-root pipeline: index k is the input of step k
  logic [cdcc_pkg::SUM_W-1:0]    rad_s  [RB+1];
  logic [cdcc_pkg::DIST_W-1:0]   root_s [RB+1];
  logic [cdcc_pkg::REM_W-1:0]    rem_s  [RB+1];

  assign chan[0] = pixel_i[3*CW-1:2*CW];
  assign chan[1] = pixel_i[2*CW-1:CW];
  assign chan[2] = pixel_i[CW-1:0];
  assign refc[0] = cfg_i.ref_red;
  assign refc[1] = cfg_i.ref_green;
  assign refc[2] = cfg_i.ref_blue;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      diff[c] = (chan[c] > refc[c]) ? (chan[c] - refc[c]) : (refc[c] - chan[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < 3; c++) begin
        sq_q[c] <= cdcc_pkg::SQ_W'(diff[c]) * cdcc_pkg::SQ_W'(diff[c]);
      end
      sum_q <= cdcc_pkg::SUM_W'(sq_q[0]) + cdcc_pkg::SUM_W'(sq_q[1])
             + cdcc_pkg::SUM_W'(sq_q[2]);
    end
  end

  assign rad_s[0]  = sum_q;
  assign root_s[0] = '0;
  assign rem_s[0]  = '0;

  for (genvar k = 0; k < RB; k++) begin : g_step
    logic [cdcc_pkg::REM_W+1:0]   cur;
    logic [cdcc_pkg::REM_W-1:0]   trial;
    logic                         take;
    logic [cdcc_pkg::SUM_W-1:0]   rad_q;
    logic [cdcc_pkg::DIST_W-1:0]  root_q;
    logic [cdcc_pkg::REM_W-1:0]   rem_q;

    // bring down the next two radicand bits, try root*4+1
    always_comb begin
      cur   = {rem_s[k], rad_s[k][cdcc_pkg::SUM_W-1 -: 2]};
      trial = {root_s[k][cdcc_pkg::DIST_W-2:0], 2'b01};
      take  = (cur >= (cdcc_pkg::REM_W+2)'(trial));
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q  <= take ? cdcc_pkg::REM_W'(cur - (cdcc_pkg::REM_W+2)'(trial))
                       : cur[cdcc_pkg::REM_W-1:0];
        root_q <= {root_s[k][cdcc_pkg::DIST_W-2:0], take};
        rad_q  <= rad_s[k] << 2;
      end
    end

    assign rad_s[k+1]  = rad_q;
    assign root_s[k+1] = root_q;
    assign rem_s[k+1]  = rem_q;
  end

  assign dist_o = root_s[RB];

endmodule

`default_nettype wire

// File: sv/cdcc_merge.sv
// cdcc_merge: compares lane distances with the thresholds, counts close
// pixels and holds the result beat. depends on cdcc_pkg.
`default_nettype none

module cdcc_merge #(
  parameter int CELL_PIXELS = cdcc_pkg::CELL_PIXELS_DEF
) (
  input  wire logic                                                clk_i,
  input  wire logic                                                rst_ni,
  input  wire logic                                                en_i,
  input  wire logic                                                vld_i,
  input  wire cdcc_pkg::cfg_t                                      cfg_i,
  input  wire logic [cdcc_pkg::LANES-1:0][cdcc_pkg::DIST_W-1:0]    dist_i,
  output logic                                                     valid_o,
  output cdcc_pkg::res_t                                           res_o
);

  logic [cdcc_pkg::CNT_W-1:0]  cnt;
  logic                        too_far;
  logic                        valid_q;
  cdcc_pkg::res_t              res_q, res_d;

  always_comb begin
    cnt     = '0;
    too_far = 1'b0;
    for (int i = 0; i < cdcc_pkg::LANES; i++) begin
      if (i < CELL_PIXELS) begin
        if (dist_i[i] < cfg_i.close_thr) cnt = cnt + cdcc_pkg::CNT_W'(1);
        if (dist_i[i] > cfg_i.far_thr)   too_far = 1'b1;
      end
    end
    res_d.is_vegetation = (cnt != '0) && !too_far;
    res_d.close_count   = cnt;
    res_d.lane_dist     = dist_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

// File: sv/color_distance_cell_classifier_top.sv
// Colour distance cell classifier. Takes one 4x2 pixel cell per beat and
// returns one result beat per cell: the eight truncated colour distances to
// the reference colour, the number of pixels closer than close_threshold,
// and the vegetation flag (some pixel close, none beyond far_threshold).
// A cell is accepted every clock unless the output stalls; each accepted cell
// passes squaring, summing, nine square-root steps (one result bit per step,
// replicated in each pixel lane) and the output register to its result beat.
// The whole pipeline advances together, so input ready drops only while a
// result beat is held at the output waiting to be taken. Registers sit on an
// apb port at byte address 4*index and may be written only while idle.
// depends on cdcc_pkg, cdcc_if, cdcc_regs, cdcc_lane, cdcc_merge.
`default_nettype none

module color_distance_cell_classifier_top #(
  parameter int CELL_PIXELS = cdcc_pkg::CELL_PIXELS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  cdcc_pix_if.sink                                 pix_i,
  cdcc_res_if.source                               res_o,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [cdcc_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [cdcc_pkg::APB_DATA_W-1:0]     pwdata,
  output logic      [cdcc_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                     pready
);

  localparam int NVLD = cdcc_pkg::PIPE_STAGES;

  cdcc_pkg::cfg_t                                    cfg;
  cdcc_pkg::res_t                                    res;
  logic [cdcc_pkg::PIX_W-1:0]                        pix [cdcc_pkg::LANES];
  logic [cdcc_pkg::LANES-1:0][cdcc_pkg::DIST_W-1:0]  lane_dist;
  logic [NVLD-1:0]                                   vld_q;
  logic                                              en;
  logic                                              res_valid;

  cdcc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // whole pipeline moves unless the result beat is stuck
  assign en          = !res_valid || res_o.ready;
  assign pix_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NVLD-2:0], pix_i.valid};
    end
  end

  assign pix[0] = pix_i.pixel_a;
  assign pix[1] = pix_i.pixel_b;
  assign pix[2] = pix_i.pixel_c;
  assign pix[3] = pix_i.pixel_d;
  assign pix[4] = pix_i.pixel_e;
  assign pix[5] = pix_i.pixel_f;
  assign pix[6] = pix_i.pixel_g;
  assign pix[7] = pix_i.pixel_h;

  for (genvar i = 0; i < cdcc_pkg::LANES; i++) begin : g_lane
    if (i < CELL_PIXELS) begin : g_used
      cdcc_lane u_lane (
        .clk_i   (clk_i),
        .en_i    (en),
        .cfg_i   (cfg),
        .pixel_i (pix[i]),
        .dist_o  (lane_dist[i])
      );
    end else begin : g_unused
      assign lane_dist[i] = '0;
    end
  end

  cdcc_merge #(
    .CELL_PIXELS (CELL_PIXELS)
  ) u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (vld_q[NVLD-1]),
    .cfg_i   (cfg),
    .dist_i  (lane_dist),
    .valid_o (res_valid),
    .res_o   (res)
  );

  assign res_o.valid         = res_valid;
  assign res_o.is_vegetation = res.is_vegetation;
  assign res_o.close_count   = res.close_count;
  assign res_o.dist_a        = res.lane_dist[0];
  assign res_o.dist_b        = res.lane_dist[1];
  assign res_o.dist_c        = res.lane_dist[2];
  assign res_o.dist_d        = res.lane_dist[3];
  assign res_o.dist_e        = res.lane_dist[4];
  assign res_o.dist_f        = res.lane_dist[5];
  assign res_o.dist_g        = res.lane_dist[6];
  assign res_o.dist_h        = res.lane_dist[7];

  a_veg_needs_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.is_vegetation |-> res_o.close_count != '0)
    else $error("vegetation flagged with no close pixel");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> res_o.close_count <= cdcc_pkg::CNT_W'(CELL_PIXELS))
    else $error("close count exceeds used lanes");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline moved while output stalled");

endmodule

`default_nettype wire

// File: tb/cdcc_checker.sv
`timescale 1ns / 1ps
// cdcc_checker: watches the pixel, result and register ports of the colour
// distance cell classifier, predicts every result beat and compares it.
// depends on cdcc_pkg and the cdcc_pix_if / cdcc_res_if interfaces.
module cdcc_checker #(
  parameter int CELL_PIXELS = cdcc_pkg::CELL_PIXELS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  cdcc_pix_if                                 pix_i,
  cdcc_res_if                                 res_i,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic                                pready,
  input  logic [cdcc_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [cdcc_pkg::APB_DATA_W-1:0]     pwdata,
  input  logic [cdcc_pkg::APB_DATA_W-1:0]     prdata,
  output int                                  failures_o,
  output int                                  outstanding_o
);
  import cdcc_pkg::*;

  typedef logic [LANES-1:0][PIX_W-1:0] cell_t;

  localparam int USED_LANES = (CELL_PIXELS > LANES) ? LANES : CELL_PIXELS;

  string dist_names [LANES] = '{"dist_a", "dist_b", "dist_c", "dist_d",
                                "dist_e", "dist_f", "dist_g", "dist_h"};

  cfg_t                    cfg;
  res_t                    pending_results [$];
  res_t                    got;
  res_t                    want;
  cell_t                   beat_px;
  logic [REG_IDX_W-1:0]    idx;
  logic [APB_DATA_W-1:0]   reg_val;
  int                      failures = 0;
  int                      in_flight = 0;

  assign failures_o    = failures;
  assign outstanding_o = in_flight;

  // floor of the euclidean distance, one root bit at a time from the top
  function automatic logic [DIST_W-1:0] colour_dist(logic [PIX_W-1:0] px, cfg_t c);
    int dr, dg, db, sum, root, trial;
    dr = int'(px[2*CHAN_W +: CHAN_W]) - int'(c.ref_red);
    dg = int'(px[CHAN_W +: CHAN_W]) - int'(c.ref_green);
    db = int'(px[0 +: CHAN_W]) - int'(c.ref_blue);
    sum = dr * dr + dg * dg + db * db;
    root = 0;
    for (int b = DIST_W - 1; b >= 0; b--) begin
      trial = root | (1 << b);
      if (trial * trial <= sum) root = trial;
    end
    return DIST_W'(root);
  endfunction

  function automatic res_t classify_cell(cell_t px, cfg_t c);
    res_t r;
    logic rejected;
    r = '0;
    rejected = 1'b0;
    // lanes past the configured cell size stay at zero distance
    for (int i = 0; i < USED_LANES; i++) begin
      r.lane_dist[i] = colour_dist(px[i], c);
      if (r.lane_dist[i] < c.close_thr) r.close_count = r.close_count + 1'b1;
      if (r.lane_dist[i] > c.far_thr) rejected = 1'b1;
    end
    r.is_vegetation = (r.close_count != '0) && !rejected;
    return r;
  endfunction

  task automatic compare_field(string name, logic [APB_DATA_W-1:0] exp_val,
                               logic [APB_DATA_W-1:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
      failures++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg = '{ref_red: '0, ref_green: '0, ref_blue: '0, close_thr: '0,
              far_thr: FAR_THR_RESET};
      pending_results.delete();
      in_flight <= 0;
    end else begin
      if (psel && penable && pready) begin
        idx = paddr[APB_ADDR_W-1:2];
        if (pwrite) begin
          // writes to unmapped indexes fall through and change nothing
          case (idx)
            REG_REF_RED:   cfg.ref_red   = pwdata[CHAN_W-1:0];
            REG_REF_GREEN: cfg.ref_green = pwdata[CHAN_W-1:0];
            REG_REF_BLUE:  cfg.ref_blue  = pwdata[CHAN_W-1:0];
            REG_CLOSE_THR: cfg.close_thr = pwdata[THR_W-1:0];
            REG_FAR_THR:   cfg.far_thr   = pwdata[THR_W-1:0];
            default: ;
          endcase
        end else if (idx <= REG_IDX_W'(REG_FAR_THR)) begin
          case (idx)
            REG_REF_RED:   reg_val = APB_DATA_W'(cfg.ref_red);
            REG_REF_GREEN: reg_val = APB_DATA_W'(cfg.ref_green);
            REG_REF_BLUE:  reg_val = APB_DATA_W'(cfg.ref_blue);
            REG_CLOSE_THR: reg_val = APB_DATA_W'(cfg.close_thr);
            REG_FAR_THR:   reg_val = APB_DATA_W'(cfg.far_thr);
            default:       reg_val = '0;
          endcase
          compare_field("prdata", reg_val, prdata);
        end
      end

      if (res_i.valid && res_i.ready) begin
        got.is_vegetation = res_i.is_vegetation;
        got.close_count   = res_i.close_count;
        got.lane_dist[0] = res_i.dist_a;
        got.lane_dist[1] = res_i.dist_b;
        got.lane_dist[2] = res_i.dist_c;
        got.lane_dist[3] = res_i.dist_d;
        got.lane_dist[4] = res_i.dist_e;
        got.lane_dist[5] = res_i.dist_f;
        got.lane_dist[6] = res_i.dist_g;
        got.lane_dist[7] = res_i.dist_h;
        if (pending_results.size() == 0) begin
          $error("result beat with no cell pending");
          failures++;
        end else begin
          want = pending_results.pop_front();
          compare_field("is_vegetation", want.is_vegetation, got.is_vegetation);
          compare_field("close_count", want.close_count, got.close_count);
          for (int i = 0; i < LANES; i++)
            compare_field(dist_names[i], want.lane_dist[i], got.lane_dist[i]);
        end
      end

      if (pix_i.valid && pix_i.ready) begin
        beat_px = {pix_i.pixel_h, pix_i.pixel_g, pix_i.pixel_f, pix_i.pixel_e,
                   pix_i.pixel_d, pix_i.pixel_c, pix_i.pixel_b, pix_i.pixel_a};
        pending_results.push_back(classify_cell(beat_px, cfg));
      end

      in_flight <= pending_results.size();
    end
  end

endmodule

// File: tb/color_distance_cell_classifier_top_test.sv
`timescale 1ns / 1ps
// color_distance_cell_classifier_top_test: drives directed and random pixel
// cells and register traffic into the classifier, stalls the result side and
// gives the verdict. depends on cdcc_pkg, cdcc_if, cdcc_checker and the rtl.
module color_distance_cell_classifier_top_test;
  import cdcc_pkg::*;

  localparam int CELL_PIXELS     = CELL_PIXELS_DEF;
  localparam int RANDOM_PHASES   = 8;
  localparam int CELLS_PER_PHASE = 212;
  localparam int SETTLE_CYCLES   = 16;  // idle wait after every result beat is taken
  localparam int RESET_CYCLES    = 7;
  localparam int REG_UNMAPPED_LO = int'(REG_FAR_THR) + 1;
  localparam logic [THR_W-1:0] THR_MAX = '1;

  typedef logic [LANES-1:0][PIX_W-1:0] cell_t;
  typedef enum int {SINK_OPEN, SINK_LIGHT, SINK_HEAVY, SINK_PERIODIC} sink_mode_e;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic                   pready;
  logic [APB_ADDR_W-1:0]  paddr;
  logic [APB_DATA_W-1:0]  pwdata;
  logic [APB_DATA_W-1:0]  prdata;
  int                     failures;
  int                     outstanding;
  logic                   sending;
  int                     burst_left;

  cdcc_pix_if pix ();
  cdcc_res_if res ();

  color_distance_cell_classifier_top #(.CELL_PIXELS(CELL_PIXELS)) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pix_i   (pix),
    .res_o   (res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  cdcc_checker #(.CELL_PIXELS(CELL_PIXELS)) cell_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pix_i         (pix),
    .res_i         (res),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .failures_o    (failures),
    .outstanding_o (outstanding)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin : watchdog
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end

  // result side stalls on its own pattern, changing mode every so often
  initial begin : result_sink
    sink_mode_e mode;
    int hold;
    int cyc;
    res.ready = 1'b0;
    cyc = 0;
    @(posedge rst_ni);
    forever begin
      mode = sink_mode_e'($urandom_range(0, 3));
      hold = $urandom_range(40, 200);
      repeat (hold) begin
        @(posedge clk_i);
        cyc++;
        case (mode)
          SINK_OPEN:  res.ready <= 1'b1;
          SINK_LIGHT: res.ready <= ($urandom_range(0, 3) != 0);
          SINK_HEAVY: res.ready <= ($urandom_range(0, 3) == 0);
          default:    res.ready <= ((cyc % 7) < 3);
        endcase
      end
    end
  end

  // one beat, then the burst/gap pacing of the sender
  task automatic send_cell(cell_t px_cell);
    int gap;
    pix.valid <= 1'b1;
    {pix.pixel_h, pix.pixel_g, pix.pixel_f, pix.pixel_e,
     pix.pixel_d, pix.pixel_c, pix.pixel_b, pix.pixel_a} <= px_cell;
    sending = 1'b1;
    do @(posedge clk_i); while (!pix.ready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        pix.valid <= 1'b0;
        sending = 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // stop sending and wait until every result beat has been taken
  task automatic settle();
    if (sending) begin
      pix.valid <= 1'b0;
      sending = 1'b0;
    end
    do @(posedge clk_i); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic reg_access(logic wr, int idx, logic [APB_DATA_W-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {REG_IDX_W'(idx), 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic read_all_regs();
    for (int i = int'(REG_REF_RED); i <= int'(REG_FAR_THR); i++)
      reg_access(1'b0, i, '0);
  endtask

  task automatic configure(logic [PIX_W-1:0] centre, logic [THR_W-1:0] close_thr,
                           logic [THR_W-1:0] far_thr);
    reg_access(1'b1, REG_REF_RED,   APB_DATA_W'(centre[2*CHAN_W +: CHAN_W]));
    reg_access(1'b1, REG_REF_GREEN, APB_DATA_W'(centre[CHAN_W +: CHAN_W]));
    reg_access(1'b1, REG_REF_BLUE,  APB_DATA_W'(centre[0 +: CHAN_W]));
    reg_access(1'b1, REG_CLOSE_THR, APB_DATA_W'(close_thr));
    reg_access(1'b1, REG_FAR_THR,   APB_DATA_W'(far_thr));
    read_all_regs();
  endtask

  // mostly pixels scattered around the reference colour, some noise and
  // some pixels pinned to channel extremes
  function automatic cell_t random_cell(logic [PIX_W-1:0] centre);
    cell_t px_cell;
    int spread;
    int v;
    spread = (1 << $urandom_range(0, 8)) - 1;
    for (int i = 0; i < LANES; i++) begin
      case ($urandom_range(0, 7))
        0, 1: px_cell[i] = PIX_W'($urandom());
        2: begin
          for (int ch = 0; ch < 3; ch++)
            px_cell[i][ch*CHAN_W +: CHAN_W] = ($urandom_range(0, 1) != 0) ? '1 : '0;
        end
        default: begin
          for (int ch = 0; ch < 3; ch++) begin
            v = int'(centre[ch*CHAN_W +: CHAN_W]) + int'($urandom_range(0, 2 * spread))
                - spread;
            px_cell[i][ch*CHAN_W +: CHAN_W] = CHAN_W'((v < 0) ? 0 : (v > 255) ? 255 : v);
          end
        end
      endcase
    end
    return px_cell;
  endfunction

  initial begin : stimulus
    logic [PIX_W-1:0] centre;
    logic [THR_W-1:0] close_thr;
    logic [THR_W-1:0] far_thr;

    rst_ni    = 1'b0;
    pix.valid = 1'b0;
    {pix.pixel_h, pix.pixel_g, pix.pixel_f, pix.pixel_e,
     pix.pixel_d, pix.pixel_c, pix.pixel_b, pix.pixel_a} = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    sending    = 1'b0;
    burst_left = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values: black reference and a zero close threshold, so nothing
    // complies and every cell is open ground
    read_all_regs();
    send_cell({LANES{24'h000000}});
    send_cell({LANES{24'hFFFFFF}});
    send_cell({24'h000000, 24'hFFFFFF, 24'h7F7F7F, 24'h808080,
               24'h010101, 24'h0000FF, 24'h00FF00, 24'hFF0000});
    settle();

    // mid reference; threshold edges are strict on both sides
    centre = 24'h8040C0;
    configure(centre, 9'd60, 9'd120);
    for (int i = REG_UNMAPPED_LO; i < 2 ** REG_IDX_W; i++)
      reg_access(1'b1, i, $urandom());
    read_all_regs();
    send_cell({LANES{24'h8040C0}});
    send_cell({24'h000000, {7{24'h8040C0}}});
    send_cell({LANES{24'h000000}});
    send_cell({{4{24'h8040C0}}, 24'h4440C0, 24'hF840C0, 24'hBC40C0, 24'hBB40C0});
    send_cell({{5{24'h8040C0}}, 24'hF940C0, 24'hBC40C0, 24'hBB40C0});
    settle();

    // thresholds at the top of the field: everything complies, nothing rejects
    configure(24'hFFFFFF, THR_MAX, THR_MAX);
    send_cell({LANES{24'h000000}});
    send_cell({LANES{24'hFFFFFF}});
    send_cell(random_cell(24'hFFFFFF));
    settle();

    // far threshold zero: any nonzero distance rejects the cell
    configure(24'h000000, FAR_THR_RESET + 1'b1, '0);
    send_cell({LANES{24'h000000}});
    send_cell({{7{24'h000000}}, 24'h000001});
    send_cell({LANES{24'hFFFFFF}});
    settle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      for (int ch = 0; ch < 3; ch++) begin
        case ($urandom_range(0, 3))
          0:       centre[ch*CHAN_W +: CHAN_W] = '0;
          1:       centre[ch*CHAN_W +: CHAN_W] = '1;
          default: centre[ch*CHAN_W +: CHAN_W] = CHAN_W'($urandom());
        endcase
      end
      case (p)
        0: begin
          close_thr = '0;
          far_thr   = '0;
        end
        1: begin
          close_thr = THR_MAX;
          far_thr   = THR_MAX;
        end
        2: begin
          close_thr = FAR_THR_RESET;
          far_thr   = FAR_THR_RESET;
        end
        default: begin
          close_thr = THR_W'($urandom_range(1, 160));
          far_thr   = ($urandom_range(0, 3) != 0)
                      ? THR_W'($urandom_range(close_thr, FAR_THR_RESET))
                      : THR_W'($urandom());
        end
      endcase
      configure(centre, close_thr, far_thr);
      repeat (CELLS_PER_PHASE) send_cell(random_cell(centre));
      settle();
    end

    if (failures == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// File: filelist.f
sv/cdcc_pkg.sv
sv/cdcc_if.sv
sv/cdcc_regs.sv
sv/cdcc_lane.sv
sv/cdcc_merge.sv
sv/color_distance_cell_classifier_top.sv
tb/cdcc_checker.sv
tb/color_distance_cell_classifier_top_test.sv
